/* rtl/core/ray_sphere_intersect_core_macros.svh */
// Assertion macros shared by the ray/sphere intersection core.
`ifndef RAY_SPHERE_INTERSECT_CORE_MACROS_SVH
`define RAY_SPHERE_INTERSECT_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define RSI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication checked at every clock edge outside reset.
`define RSI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define RSI_ASSERT(lbl, clk, rst_n, prop, msg)
`define RSI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/core/rsi_pkg.sv */
package rsi_pkg;

    // Fixed-point format and datapath sizes.
    localparam int FRAC_BITS = 16;
    localparam int RSQ_W     = 31;
    localparam int T_W       = 31;
    localparam int SQ_STEPS  = 64;
    localparam int DIV_STEPS = T_W;
    localparam int DIV_W     = 96;
    localparam int NUM_W     = 65;

    localparam logic [RSQ_W-1:0] RSQ_RESET = RSQ_W'(1) << (FRAC_BITS - 2);
    localparam logic [T_W-1:0]   T_MAX     = '1;

    // One ray as it enters the core.
    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
    } ray_t;

    // Per-item data that travels alongside the square root chain.
    typedef struct packed {
        ray_t        ray;
        logic        miss;
        logic        hnonpos;
        logic        cneg;
        logic        cmag_zero;
        logic [63:0] hmag;
        logic [63:0] amag;
    } side_t;

    // Working state of one square root step.
    typedef struct packed {
        logic [127:0] dsh;
        logic [65:0]  rem;
        logic [63:0]  root;
    } sq_t;

    // Per-item data that travels alongside the divider chain.
    typedef struct packed {
        ray_t        ray;
        logic        miss;
        logic        sat;
        logic [63:0] amag;
    } dside_t;

    // Working state of one division step.
    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [T_W-1:0]   quo;
    } dv_t;

    // One finished result.
    typedef struct packed {
        logic               hit;
        logic [T_W-1:0]     t;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } res_t;

endpackage

/* rtl/core/rsi_front.sv */
module rsi_front
    import rsi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  ray_t             in_ray,
    input  logic [RSQ_W-1:0] rsq,
    output logic             out_valid,
    output side_t            out_side,
    output logic [127:0]     out_disc
);

    logic [5:0] v_reg;

    logic signed [31:0] o_v [3];
    logic signed [31:0] d_v [3];
    logic [31:0]        mo [3];
    logic [31:0]        md [3];

    ray_t        ray1_reg;
    logic [63:0] pdd_reg [3];
    logic [63:0] poo_reg [3];
    logic [63:0] pdo_reg [3];
    logic [2:0]  sneg_reg;

    ray_t        ray2_reg;
    logic [63:0] a2_reg;
    logic [63:0] s2_reg;
    logic [63:0] hp2_reg;
    logic [63:0] hn2_reg;

    side_t       side3_reg;
    logic [63:0] cmag3_reg;

    side_t       side4_reg;
    logic [63:0] hh00_reg, hh01_reg, hh11_reg;
    logic [63:0] ac00_reg, ac01_reg, ac10_reg, ac11_reg;

    side_t        side5_reg;
    logic [127:0] hh5_reg;
    logic [127:0] ac5_reg;

    side_t        side6_reg;
    logic [127:0] disc6_reg;

    // Operand magnitudes of the incoming ray.
    always_comb
    begin
        o_v[0] = in_ray.ox;
        o_v[1] = in_ray.oy;
        o_v[2] = in_ray.oz;
        d_v[0] = in_ray.dx;
        d_v[1] = in_ray.dy;
        d_v[2] = in_ray.dz;
        for (int i = 0; i < 3; i++)
        begin
            mo[i] = o_v[i][31] ? 32'(-o_v[i]) : 32'(o_v[i]);
            md[i] = d_v[i][31] ? 32'(-d_v[i]) : 32'(d_v[i]);
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    // Stage 1: per-axis products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ray1_reg <= in_ray;
            for (int i = 0; i < 3; i++)
            begin
                pdd_reg[i]  <= md[i] * md[i];
                poo_reg[i]  <= mo[i] * mo[i];
                pdo_reg[i]  <= md[i] * mo[i];
                sneg_reg[i] <= o_v[i][31] ^ d_v[i][31];
            end
        end
    end

    // Stage 2: a = d.d, o.o, and d.o split by sign.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ray2_reg <= ray1_reg;
            a2_reg   <= pdd_reg[0] + pdd_reg[1] + pdd_reg[2];
            s2_reg   <= poo_reg[0] + poo_reg[1] + poo_reg[2];
            hp2_reg  <= (sneg_reg[0] ? 64'd0 : pdo_reg[0])
                      + (sneg_reg[1] ? 64'd0 : pdo_reg[1])
                      + (sneg_reg[2] ? 64'd0 : pdo_reg[2]);
            hn2_reg  <= (sneg_reg[0] ? pdo_reg[0] : 64'd0)
                      + (sneg_reg[1] ? pdo_reg[1] : 64'd0)
                      + (sneg_reg[2] ? pdo_reg[2] : 64'd0);
        end
    end

    // Stage 3: signs and magnitudes of b/2 and c.
    logic [63:0] r_full;
    logic        hneg3;
    logic [63:0] hmag3;
    logic        cneg3;

    always_comb
    begin
        r_full = 64'(rsq) << FRAC_BITS;
        hneg3  = hn2_reg > hp2_reg;
        hmag3  = hneg3 ? hn2_reg - hp2_reg : hp2_reg - hn2_reg;
        cneg3  = s2_reg < r_full;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side3_reg.ray       <= ray2_reg;
            side3_reg.miss      <= (a2_reg == 64'd0);
            side3_reg.hnonpos   <= hneg3 || (hmag3 == 64'd0);
            side3_reg.cneg      <= cneg3;
            side3_reg.cmag_zero <= (s2_reg == r_full);
            side3_reg.hmag      <= hmag3;
            side3_reg.amag      <= a2_reg;
            cmag3_reg           <= cneg3 ? r_full - s2_reg : s2_reg - r_full;
        end
    end

    // Stage 4: 32-bit partial products of (b/2)^2 and a*c.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side4_reg <= side3_reg;
            hh00_reg  <= side3_reg.hmag[31:0]  * side3_reg.hmag[31:0];
            hh01_reg  <= side3_reg.hmag[31:0]  * side3_reg.hmag[63:32];
            hh11_reg  <= side3_reg.hmag[63:32] * side3_reg.hmag[63:32];
            ac00_reg  <= side3_reg.amag[31:0]  * cmag3_reg[31:0];
            ac01_reg  <= side3_reg.amag[31:0]  * cmag3_reg[63:32];
            ac10_reg  <= side3_reg.amag[63:32] * cmag3_reg[31:0];
            ac11_reg  <= side3_reg.amag[63:32] * cmag3_reg[63:32];
        end
    end

    // Stage 5: assemble the full 128-bit products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side5_reg <= side4_reg;
            hh5_reg   <= {hh11_reg, hh00_reg} + (128'(hh01_reg) << 33);
            ac5_reg   <= {ac11_reg, ac00_reg} + (128'(ac01_reg) << 32)
                       + (128'(ac10_reg) << 32);
        end
    end

    // Stage 6: discriminant, with a miss when it goes negative.
    logic [128:0] diff6;
    side_t        side6_next;

    always_comb
    begin
        diff6           = {1'b0, hh5_reg} - {1'b0, ac5_reg};
        side6_next      = side5_reg;
        side6_next.miss = side5_reg.miss || (!side5_reg.cneg && diff6[128]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side6_reg <= side6_next;
            disc6_reg <= side5_reg.cneg ? hh5_reg + ac5_reg : diff6[127:0];
        end
    end

    assign out_valid = v_reg[5];
    assign out_side  = side6_reg;
    assign out_disc  = disc6_reg;

endmodule

/* rtl/core/rsi_sqrt_cell.sv */
module rsi_sqrt_cell
    import rsi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  side_t in_side,
    input  sq_t   in_sq,
    output logic  out_valid,
    output side_t out_side,
    output sq_t   out_sq
);

    logic        valid_reg;
    side_t       side_reg;
    sq_t         sq_reg;

    logic [65:0] rem2;
    logic [65:0] trial;
    logic [66:0] diff;
    logic        ge;

    // One root bit: bring down two radicand bits and try root*4+1.
    always_comb
    begin
        rem2  = {in_sq.rem[63:0], in_sq.dsh[127:126]};
        trial = {in_sq.root, 2'b01};
        diff  = {1'b0, rem2} - {1'b0, trial};
        ge    = !diff[66];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg    <= in_side;
            sq_reg.dsh  <= in_sq.dsh << 2;
            sq_reg.rem  <= ge ? diff[65:0] : rem2;
            sq_reg.root <= {in_sq.root[62:0], ge};
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_sq    = sq_reg;

endmodule

/* rtl/core/rsi_div_cell.sv */
module rsi_div_cell
    import rsi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  dside_t in_side,
    input  dv_t    in_dv,
    output logic   out_valid,
    output dside_t out_side,
    output dv_t    out_dv
);

    logic             valid_reg;
    dside_t           side_reg;
    dv_t              dv_reg;

    logic [DIV_W-1:0] aw;
    logic [DIV_W:0]   diff;
    logic             ge;
    logic [DIV_W-1:0] rem_sel;

    // One quotient bit: compare against a shifted to the top quotient weight.
    always_comb
    begin
        aw      = DIV_W'(in_side.amag) << (T_W - 1);
        diff    = {1'b0, in_dv.rem} - {1'b0, aw};
        ge      = !diff[DIV_W];
        rem_sel = ge ? diff[DIV_W-1:0] : in_dv.rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg   <= in_side;
            dv_reg.rem <= rem_sel << 1;
            dv_reg.quo <= {in_dv.quo[T_W-2:0], ge};
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_dv    = dv_reg;

endmodule

/* rtl/core/rsi_point.sv */
module rsi_point
    import rsi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  dside_t in_side,
    input  dv_t    in_dv,
    output logic   out_valid,
    output res_t   out_res
);

    logic [1:0]         v_reg;
    logic               hit1_reg;
    logic [T_W-1:0]     t1_reg;
    logic signed [63:0] prod1_reg [3];
    logic signed [31:0] o1_reg [3];
    res_t               res_reg;

    logic [T_W-1:0]     t_sel;
    logic signed [31:0] d_v [3];
    logic signed [31:0] o_v [3];

    // Final t: zero on a miss, clamped when the quotient overflowed.
    always_comb
    begin
        t_sel  = in_side.miss ? '0 : (in_side.sat ? T_MAX : in_dv.quo);
        d_v[0] = in_side.ray.dx;
        d_v[1] = in_side.ray.dy;
        d_v[2] = in_side.ray.dz;
        o_v[0] = in_side.ray.ox;
        o_v[1] = in_side.ray.oy;
        o_v[2] = in_side.ray.oz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[0], in_valid};
        end
    end

    // Stage 1: t * d for each axis.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit1_reg <= !in_side.miss;
            t1_reg   <= t_sel;
            for (int i = 0; i < 3; i++)
            begin
                prod1_reg[i] <= $signed({1'b0, t_sel}) * d_v[i];
                o1_reg[i]    <= o_v[i];
            end
        end
    end

    // Stage 2: o + floor(t*d), saturated to 32 signed bits, zero on a miss.
    logic signed [63:0] step [3];
    logic signed [63:0] psum [3];
    logic signed [31:0] pc   [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            step[i] = prod1_reg[i] >>> FRAC_BITS;
            psum[i] = 64'(o1_reg[i]) + step[i];
            if (psum[i][63:31] == '0 || psum[i][63:31] == '1)
            begin
                pc[i] = psum[i][31:0];
            end
            else
            begin
                pc[i] = psum[i][63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end
            if (!hit1_reg)
            begin
                pc[i] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.hit <= hit1_reg;
            res_reg.t   <= t1_reg;
            res_reg.px  <= pc[0];
            res_reg.py  <= pc[1];
            res_reg.pz  <= pc[2];
        end
    end

    assign out_valid = v_reg[1];
    assign out_res   = res_reg;

endmodule

/* rtl/core/ray_sphere_intersect_core.sv */
// Ray/sphere intersection core, fully pipelined: one ray accepted per cycle unless the output skid is full.
// From input acceptance to m_tvalid, items pass the setup stages, the 64-cell
// square root chain and the 31-cell divider chain, then the output stages.
// Throughput: one item per cycle; input stalls only once the output skid fills.
// Reset: rst_n clears all valid state and sets radius_squared to 0.25.
`include "ray_sphere_intersect_core_macros.svh"

module ray_sphere_intersect_core
    import rsi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // Configuration: radius_squared
    input  logic             cfg_we,
    input  logic [RSQ_W-1:0] cfg_wdata,
    // Input items
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [191:0]     s_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    // Result items
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [127:0]     m_tdata,   // hit_t, point_x, point_y, point_z, zero pad
    output logic             m_tuser    // hit
);

    logic [RSQ_W-1:0] rsq_reg;
    logic             en;
    ray_t             in_ray;

    // Radius register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsq_reg <= RSQ_RESET;
        end
        else if (cfg_we)
        begin
            rsq_reg <= cfg_wdata;
        end
    end

    assign in_ray.ox = s_tdata[31:0];
    assign in_ray.oy = s_tdata[63:32];
    assign in_ray.oz = s_tdata[95:64];
    assign in_ray.dx = s_tdata[127:96];
    assign in_ray.dy = s_tdata[159:128];
    assign in_ray.dz = s_tdata[191:160];

    // Quadratic setup.
    logic         fr_valid;
    side_t        fr_side;
    logic [127:0] fr_disc;

    rsi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid && s_tready),
        .in_ray    (in_ray),
        .rsq       (rsq_reg),
        .out_valid (fr_valid),
        .out_side  (fr_side),
        .out_disc  (fr_disc)
    );

    // Square root chain, one root bit per cell.
    logic  sq_v    [SQ_STEPS+1];
    side_t sq_side [SQ_STEPS+1];
    sq_t   sq_st   [SQ_STEPS+1];

    assign sq_v[0]       = fr_valid;
    assign sq_side[0]    = fr_side;
    assign sq_st[0].dsh  = fr_disc;
    assign sq_st[0].rem  = '0;
    assign sq_st[0].root = '0;

    for (genvar g = 0; g < SQ_STEPS; g++)
    begin : g_sqrt
        rsi_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_v[g]),
            .in_side   (sq_side[g]),
            .in_sq     (sq_st[g]),
            .out_valid (sq_v[g+1]),
            .out_side  (sq_side[g+1]),
            .out_sq    (sq_st[g+1])
        );
    end

    // Root selection and divider setup.
    side_t            sq_out;
    logic [NUM_W-1:0] s65;
    logic [NUM_W-1:0] h65;
    logic [NUM_W-1:0] num;
    logic [DIV_W-1:0] n_w;
    logic [DIV_W-1:0] lim;
    logic             q_miss;

    always_comb
    begin
        sq_out = sq_side[SQ_STEPS];
        s65    = NUM_W'(sq_st[SQ_STEPS].root);
        h65    = NUM_W'(sq_out.hmag);
        q_miss = sq_out.miss;
        if (sq_out.hnonpos && !sq_out.cneg)
        begin
            num = h65 - s65;
        end
        else if (sq_out.hnonpos)
        begin
            num = s65 + h65;
        end
        else
        begin
            num = s65 - h65;
            if (!sq_out.cneg && !sq_out.cmag_zero)
            begin
                q_miss = 1'b1;
            end
        end
        n_w = DIV_W'(num) << FRAC_BITS;
        lim = DIV_W'(sq_out.amag) << T_W;
    end

    logic   q_valid_reg;
    dside_t q_side_reg;
    dv_t    q_dv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            q_valid_reg <= sq_v[SQ_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_side_reg.ray  <= sq_out.ray;
            q_side_reg.miss <= q_miss;
            q_side_reg.sat  <= (n_w >= lim);
            q_side_reg.amag <= sq_out.amag;
            q_dv_reg.rem    <= n_w;
            q_dv_reg.quo    <= '0;
        end
    end

    // Divider chain, one quotient bit per cell.
    logic   dv_v    [DIV_STEPS+1];
    dside_t dv_side [DIV_STEPS+1];
    dv_t    dv_st   [DIV_STEPS+1];

    assign dv_v[0]    = q_valid_reg;
    assign dv_side[0] = q_side_reg;
    assign dv_st[0]   = q_dv_reg;

    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        rsi_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_v[g]),
            .in_side   (dv_side[g]),
            .in_dv     (dv_st[g]),
            .out_valid (dv_v[g+1]),
            .out_side  (dv_side[g+1]),
            .out_dv    (dv_st[g+1])
        );
    end

    // Hit point.
    logic pt_valid;
    res_t pt_res;

    rsi_point u_point (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_v[DIV_STEPS]),
        .in_side   (dv_side[DIV_STEPS]),
        .in_dv     (dv_st[DIV_STEPS]),
        .out_valid (pt_valid),
        .out_res   (pt_res)
    );

    // Output register with a skid entry behind it.
    logic out_valid_reg;
    logic out_valid_next;
    res_t out_reg;
    logic skid_valid_reg;
    logic skid_valid_next;
    res_t skid_reg;
    logic push;
    logic out_take;
    logic load_from_skid;
    logic load_from_pipe;
    logic load_skid;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_comb
    begin
        push            = pt_valid && en;
        out_take        = out_valid_reg && m_tready;
        load_from_skid  = out_take && skid_valid_reg;
        load_from_pipe  = push && (!out_valid_reg || out_take);
        load_skid       = push && out_valid_reg && !out_take;
        out_valid_next  = load_from_skid || load_from_pipe || (out_valid_reg && !out_take);
        skid_valid_next = load_skid || (skid_valid_reg && !out_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_from_skid)
        begin
            out_reg <= skid_reg;
        end
        else if (load_from_pipe)
        begin
            out_reg <= pt_res;
        end
        if (load_skid)
        begin
            skid_reg <= pt_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.hit;
    assign m_tdata  = {1'b0, out_reg.pz, out_reg.py, out_reg.px, out_reg.t};

    // A held skid entry always sits behind a pending output item.
    `RSI_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_reg, m_tvalid, "skid item without output item")
    // A miss result carries all-zero data.
    `RSI_ASSERT_IMPL(a_miss_zero, clk, rst_n, m_tvalid && !m_tuser, m_tdata == '0, "miss item with nonzero data")
    // The skid entry fills only when the output was stalled.
    `RSI_ASSERT_IMPL(a_skid_on_stall, clk, rst_n, $rose(skid_valid_reg), $past(m_tvalid && !m_tready), "skid filled without stall")

endmodule

/* tb/ray_sphere_checker.sv */
`timescale 1ns / 1ps

// Watches both streams of the intersection core, predicts every result from the
// accepted ray and the current squared radius, and compares in order.
module ray_sphere_checker
    import rsi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [RSQ_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [191:0]     s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [127:0]     m_tdata,
    input  logic             m_tuser,
    output int               fail_count,
    output int               pending
);

    logic [RSQ_W-1:0] radius_sq;
    res_t             expected_hits[$];

    // Exact intersection of one ray with the sphere at the origin.
    function automatic res_t intersect_ray(ray_t r, logic [RSQ_W-1:0] rsq);
        longint       o[3];
        longint       d[3];
        logic [63:0]  a_sum, s_sum, hpos, hneg_sum, hmag, cmag, rr, root, num, cand;
        logic [63:0]  mo, md;
        logic         hneg, cneg, hnonpos;
        logic [127:0] hh, ac, disc, n, lim;
        logic [T_W-1:0] t;
        longint       prod, step, p;
        res_t         res;
        res = '0;
        o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
        d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
        a_sum = 0; s_sum = 0; hpos = 0; hneg_sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mo = (o[i] < 0) ? 64'(-o[i]) : 64'(o[i]);
            md = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
            a_sum += md * md;
            s_sum += mo * mo;
            if ((d[i] < 0) != (o[i] < 0))
                hneg_sum += md * mo;
            else
                hpos += md * mo;
        end
        // A zero direction can never meet the sphere.
        if (a_sum == 0)
            return res;
        hneg    = hneg_sum > hpos;
        hmag    = hneg ? hneg_sum - hpos : hpos - hneg_sum;
        hnonpos = hneg || hmag == 0;
        rr      = 64'(rsq) << FRAC_BITS;
        cneg    = s_sum < rr;
        cmag    = cneg ? rr - s_sum : s_sum - rr;
        hh      = 128'(hmag) * 128'(hmag);
        ac      = 128'(a_sum) * 128'(cmag);
        if (!cneg)
        begin
            if (hh < ac)
                return res;
            disc = hh - ac;
        end
        else
        begin
            disc = hh + ac;
        end
        root = 0;
        for (int b = 63; b >= 0; b--)
        begin
            cand = root | (64'(1) << b);
            if (128'(cand) * 128'(cand) <= disc)
                root = cand;
        end
        // Outside and facing: near root. Inside or on the surface: far root.
        if (hnonpos && !cneg)
            num = hmag - root;
        else if (hnonpos || cneg || cmag == 0)
            num = hnonpos ? root + hmag : root - hmag;
        else
            return res;
        n   = 128'(num) << FRAC_BITS;
        lim = 128'(a_sum) << 31;
        if (n >= lim)
            t = T_MAX;
        else
            t = T_W'(n / 128'(a_sum));
        res.hit = 1'b1;
        res.t   = t;
        for (int i = 0; i < 3; i++)
        begin
            prod = longint'({33'b0, t}) * d[i];
            step = prod >>> FRAC_BITS;
            p    = o[i] + step;
            if (p > 64'sd2147483647)
                p = 64'sd2147483647;
            if (p < -64'sd2147483648)
                p = -64'sd2147483648;
            if (i == 0) res.px = 32'(p);
            else if (i == 1) res.py = 32'(p);
            else res.pz = 32'(p);
        end
        return res;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    assign pending = expected_hits.size();

    initial
    begin
        fail_count = 0;
    end

    // Track the register and queue a prediction for every accepted ray.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_sq <= RSQ_RESET;
        end
        else
        begin
            if (cfg_we)
                radius_sq <= cfg_wdata;
            if (s_tvalid && s_tready)
                expected_hits.push_back(intersect_ray(ray_t'({s_tdata[31:0], s_tdata[63:32],
                    s_tdata[95:64], s_tdata[127:96], s_tdata[159:128],
                    s_tdata[191:160]}), radius_sq));
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        res_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_hits.size() == 0)
            begin
                report("result item with no ray waiting");
            end
            else
            begin
                exp_r = expected_hits.pop_front();
                if (m_tuser !== exp_r.hit)
                    report($sformatf("hit %b, expected %b", m_tuser, exp_r.hit));
                if (m_tdata[30:0] !== exp_r.t)
                    report($sformatf("hit_t %h, expected %h", m_tdata[30:0], exp_r.t));
                if (m_tdata[62:31] !== exp_r.px)
                    report($sformatf("point_x %h, expected %h", m_tdata[62:31], exp_r.px));
                if (m_tdata[94:63] !== exp_r.py)
                    report($sformatf("point_y %h, expected %h", m_tdata[94:63], exp_r.py));
                if (m_tdata[126:95] !== exp_r.pz)
                    report($sformatf("point_z %h, expected %h", m_tdata[126:95], exp_r.pz));
                if (m_tdata[127] !== 1'b0)
                    report("padding bit of result is not zero");
            end
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import rsi_pkg::*;

    localparam int ONE = 1 << FRAC_BITS;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [RSQ_W-1:0] cfg_wdata = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [191:0]     s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [127:0]     m_tdata;
    logic             m_tuser;
    int               fail_count;
    int               pending;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;

    always #5 clk = ~clk;

    ray_sphere_intersect_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    ray_sphere_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Result side back-pressure.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one ray, with random idle cycles first, and wait for acceptance.
    task automatic send_ray(input int ox, oy, oz, dx, dy, dz);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dz, dy, dx, oz, oy, ox};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Drain the core, then write the squared radius while it is idle.
    task automatic set_radius_sq(input logic [RSQ_W-1:0] value);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (120) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Random rays: mostly aimed near the sphere, some small, some raw noise, some with zero direction.
    task automatic random_rays(input int count, input int span);
        int kind;
        int o[3];
        int d[3];
        for (int k = 0; k < count; k++)
        begin
            kind = $urandom_range(99);
            for (int i = 0; i < 3; i++)
            begin
                if (kind < 60)
                begin
                    o[i] = $signed($urandom_range(2 * span)) - span;
                    d[i] = -o[i] + $signed($urandom_range(span / 2)) - span / 4;
                end
                else if (kind < 80)
                begin
                    o[i] = $signed($urandom_range(2 * span)) - span;
                    d[i] = $signed($urandom_range(2 * span)) - span;
                end
                else if (kind < 97)
                begin
                    o[i] = $urandom;
                    d[i] = $urandom;
                end
                else
                begin
                    o[i] = $urandom;
                    d[i] = 0;
                end
            end
            send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rays at the reset radius of one half.
        send_ray(0, 0, -2 * ONE, 0, 0, ONE);                  // outside, facing
        send_ray(0, ONE / 2, -2 * ONE, 0, 0, ONE);            // tangent
        send_ray(0, 2 * ONE, -2 * ONE, 0, 0, ONE);            // misses entirely
        send_ray(0, 0, 0, 0, 0, ONE);                         // starts at center
        send_ray(ONE / 8, 0, 0, -ONE, ONE / 4, 0);            // starts inside
        send_ray(0, 0, 2 * ONE, 0, 0, ONE);                   // sphere behind
        send_ray(0, 0, ONE / 2, 0, 0, ONE);                   // on surface, leaving
        send_ray(0, 0, -ONE / 2, 0, 0, ONE);                  // on surface, entering
        send_ray(ONE, ONE, ONE, 0, 0, 0);                     // zero direction
        send_ray(0, 0, -30000 * ONE, 0, 0, 1);                // very large t
        send_ray(0, 0, 0, 0, 0, 1);                           // tiny direction, inside
        send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000, 32'h80000000, 32'h80000000);
        send_ray(32'h80000000, 32'h80000000, 32'h80000000,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_ray(32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h80000000, 32'h80000000);
        send_ray(-1, -1, -1, -1, -1, -1);
        send_ray(0, 0, 0, 32'h80000000, 0, 0);
        random_rays(300, 2 * ONE);

        // Largest radius, sender idling.
        set_radius_sq(31'h7fffffff);
        send_ray(0, 0, 0, 0, 0, ONE);
        send_ray(32'h80000000, 0, 0, 32'h7fffffff, 0, 0);
        send_idle_pct = 82;
        random_rays(320, 32767 * ONE);

        // Zero radius, receiver stalling.
        set_radius_sq('0);
        send_ray(0, 0, 0, 0, 0, ONE);
        send_ray(0, 0, -ONE, 0, 0, ONE);
        send_idle_pct  = 0;
        recv_stall_pct = 82;
        random_rays(320, ONE);

        // Unit radius, both sides idling.
        set_radius_sq(31'(ONE));
        send_idle_pct  = 26;
        recv_stall_pct = 26;
        random_rays(330, 3 * ONE);

        // Random radius, full rate.
        set_radius_sq(31'($urandom));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_rays(330, 256 * ONE);
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (120) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Run limit.
    initial
    begin
        #20ms;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
